// ----- rtl/amrpd_pkg.sv -----
// Shared types, constants and helpers for the AMR payload deframer.
package amrpd_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam int unsigned ResultCap    = 20;
  localparam logic [3:0]  RequestReset = 4'd15;
  localparam logic [2:0]  ModeReset    = 3'd7;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SPEECH = 2'd1,
    KIND_END    = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    PH_CMR    = 2'd0,
    PH_TOC    = 2'd1,
    PH_SPEECH = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  typedef enum logic [0:0] {
    CFG_OCTET_ALIGNED = 1'b0,
    CFG_DEFAULT_MODE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TOC,
    ST_SPEECH,
    ST_HDR,
    ST_END
  } state_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic       frame_done;
    logic       payload_done;
    logic [1:0] error_status;
    logic [3:0] request_code;
    logic [2:0] encoder_mode;
  } result_t;

  // Speech bits per frame type; types 8 and up carry none.
  function automatic logic [7:0] ft_bit_count(input logic [3:0] ft);
    logic [7:0] b;
    case (ft)
      4'd0:    b = 8'd95;
      4'd1:    b = 8'd103;
      4'd2:    b = 8'd118;
      4'd3:    b = 8'd134;
      4'd4:    b = 8'd148;
      4'd5:    b = 8'd159;
      4'd6:    b = 8'd204;
      4'd7:    b = 8'd244;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] frame_len(input logic [6:0] entry, input logic octet);
    logic [7:0] b;
    b = ft_bit_count(entry[6:3]);
    if (octet) begin
      b = (b + 8'd7) & 8'hF8;
    end
    return b;
  endfunction

  // Mask of the low fill bits of the reservoir.
  function automatic logic [15:0] low_mask(input logic [4:0] fill);
    logic [16:0] m;
    m = (17'd1 << fill) - 17'd1;
    return m[15:0];
  endfunction

endpackage

// ----- rtl/amr_payload_deframer.sv -----
// AMR-NB payload deframer: RTP payload bytes in, storage-format bytes out.
// Each accepted byte passes LOAD, then TOC for its entries, then SPEECH; a frame
//   header goes through HDR after a TOC memory read, and each speech byte is one
//   SPEECH step. A new byte is taken only back in IDLE, and waiting on the output
//   register stalls HDR, SPEECH and END.
// Reset: asynchronous active low; CMR expected next, request code 15, mode 7.
module amr_payload_deframer #(
  parameter int unsigned MaxFrames = amrpd_pkg::MaxFramesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       payload_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] item_kind_o,
  output logic       frame_done_o,
  output logic       payload_done_o,
  output logic [1:0] error_status_o,
  output logic [3:0] request_code_o,
  output logic [2:0] encoder_mode_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);

  localparam int unsigned AddrW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned CntW  = $clog2(MaxFrames + 1) > AddrW ?
                                  $clog2(MaxFrames + 1) : AddrW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxFrames);
  localparam logic [4:0] CapAll = 5'(amrpd_pkg::ResultCap);
  localparam logic [4:0] CapEnd = 5'(amrpd_pkg::ResultCap - 1);

  amrpd_pkg::state_e state_q, state_d;
  amrpd_pkg::phase_e phase_q, phase_d;
  logic [15:0]     res_q, res_d;
  logic [4:0]      fill_q, fill_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic [7:0]      left_q, left_d;
  logic [3:0]      req_q, req_d;
  logic [2:0]      mode_q, mode_d;
  logic [1:0]      latch_q, latch_d;
  logic            octet_q;
  logic [4:0]      cnt_q, cnt_d;
  logic [7:0]      byte_q;
  logic            end_q;

  // TOC memory port signals
  logic             mem_we, mem_re;
  logic [6:0]       mem_wdata, mem_rdata;

  // output register
  logic               push, slot_free;
  amrpd_pkg::result_t res_out, res_new;

  // bit extraction
  logic [3:0]  take_n;
  logic [4:0]  fill_after;
  logic [15:0] shifted;
  logic [7:0]  take_v;
  logic [4:0]  lim;
  logic        capped;
  logic [7:0]  hdr_bits;
  logic [7:0]  toc_e;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == amrpd_pkg::ST_IDLE);

  amrpd_toc_mem #(.Depth(MaxFrames), .AddrW(AddrW)) u_toc_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cursor_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  amrpd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_new),
    .free_o  (slot_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign out_byte_o     = res_out.out_byte;
  assign item_kind_o    = res_out.item_kind;
  assign frame_done_o   = res_out.frame_done;
  assign payload_done_o = res_out.payload_done;
  assign error_status_o = res_out.error_status;
  assign request_code_o = res_out.request_code;
  assign encoder_mode_o = res_out.encoder_mode;

  // take_n bits off the top of the filled part of the reservoir
  always_comb begin
    take_n = 4'd8;
    case (state_q)
      amrpd_pkg::ST_LOAD:   take_n = octet_q ? 4'd8 : 4'd4;
      amrpd_pkg::ST_TOC:    take_n = octet_q ? 4'd8 : 4'd6;
      amrpd_pkg::ST_SPEECH: take_n = (left_q < 8'd8) ? left_q[3:0] : 4'd8;
      default:              take_n = 4'd8;
    endcase
  end

  always_comb begin
    logic [15:0] rsrc;
    logic [4:0]  fsrc;
    logic [15:0] tmask;
    rsrc = res_q;
    fsrc = fill_q;
    if (state_q == amrpd_pkg::ST_LOAD) begin
      rsrc = {res_q[7:0], byte_q};
      fsrc = fill_q + 5'd8;
    end
    fill_after = fsrc - {1'b0, take_n};
    shifted    = rsrc >> fill_after;
    tmask      = amrpd_pkg::low_mask({1'b0, take_n});
    take_v     = shifted[7:0] & tmask[7:0];
  end

  assign lim      = end_q ? CapEnd : CapAll;
  assign capped   = (cnt_q >= lim);
  assign hdr_bits = amrpd_pkg::frame_len(mem_rdata, octet_q);
  assign toc_e    = octet_q ? take_v : {take_v[5:0], 2'b00};

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    res_d     = res_q;
    fill_d    = fill_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    left_d    = left_q;
    req_d     = req_q;
    mode_d    = mode_q;
    latch_d   = latch_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_wdata = toc_e[6:0];
    mem_re    = 1'b0;
    push      = 1'b0;
    res_new   = '{out_byte: 8'd0, item_kind: amrpd_pkg::KIND_HEADER, frame_done: 1'b0,
                  payload_done: 1'b0, error_status: amrpd_pkg::ERR_OK,
                  request_code: req_q, encoder_mode: mode_q};

    case (state_q)
      amrpd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = 5'd0;
          state_d = amrpd_pkg::ST_LOAD;
        end
      end

      // append the byte unless skipping; the CMR comes off the front of a new payload
      amrpd_pkg::ST_LOAD: begin
        if (phase_q != amrpd_pkg::PH_SKIP) begin
          if (phase_q == amrpd_pkg::PH_CMR) begin
            req_d   = octet_q ? take_v[7:4] : take_v[3:0];
            fill_d  = fill_after;
            res_d   = {res_q[7:0], byte_q} & amrpd_pkg::low_mask(fill_after);
            phase_d = amrpd_pkg::PH_TOC;
            count_d = '0;
          end else begin
            res_d  = {res_q[7:0], byte_q};
            fill_d = fill_q + 5'd8;
          end
        end
        state_d = amrpd_pkg::ST_TOC;
      end

      // one TOC entry per cycle
      amrpd_pkg::ST_TOC: begin
        if (phase_q == amrpd_pkg::PH_TOC && fill_q >= {1'b0, take_n}) begin
          fill_d = fill_after;
          res_d  = res_q & amrpd_pkg::low_mask(fill_after);
          if (count_q < MaxCnt) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (!toc_e[7]) begin
            phase_d  = amrpd_pkg::PH_SPEECH;
            cursor_d = '0;
            left_d   = 8'd0;
          end else if (count_d >= MaxCnt) begin
            latch_d = amrpd_pkg::ERR_OVERFLOW;
            phase_d = amrpd_pkg::PH_SKIP;
            res_d   = 16'd0;
            fill_d  = 5'd0;
          end
        end else begin
          state_d = amrpd_pkg::ST_SPEECH;
        end
      end

      amrpd_pkg::ST_SPEECH: begin
        if (phase_q != amrpd_pkg::PH_SPEECH) begin
          state_d = amrpd_pkg::ST_END;
        end else if (left_q == 8'd0) begin
          if (cursor_q >= count_q || cursor_q >= MaxCnt) begin
            phase_d = amrpd_pkg::PH_SKIP;
            res_d   = 16'd0;
            fill_d  = 5'd0;
            state_d = amrpd_pkg::ST_END;
          end else begin
            mem_re  = 1'b1;
            state_d = amrpd_pkg::ST_HDR;
          end
        end else if (fill_q < {1'b0, take_n}) begin
          state_d = amrpd_pkg::ST_END;
        end else if (capped || slot_free) begin
          push             = !capped;
          cnt_d            = capped ? cnt_q : cnt_q + 5'd1;
          res_new.out_byte  = take_v << (4'd8 - take_n);
          res_new.item_kind = amrpd_pkg::KIND_SPEECH;
          res_new.frame_done = (left_q == {4'd0, take_n});
          fill_d = fill_after;
          res_d  = res_q & amrpd_pkg::low_mask(fill_after);
          left_d = left_q - {4'd0, take_n};
          if (left_q == {4'd0, take_n}) begin
            cursor_d = cursor_q + 1'b1;
          end
        end
      end

      // header byte from the entry just read
      amrpd_pkg::ST_HDR: begin
        if (capped || slot_free) begin
          push               = !capped;
          cnt_d              = capped ? cnt_q : cnt_q + 5'd1;
          res_new.out_byte   = {1'b0, mem_rdata};
          res_new.item_kind  = amrpd_pkg::KIND_HEADER;
          res_new.frame_done = (hdr_bits == 8'd0);
          if (hdr_bits == 8'd0) begin
            cursor_d = cursor_q + 1'b1;
          end else begin
            left_d = hdr_bits;
          end
          state_d = amrpd_pkg::ST_SPEECH;
        end
      end

      amrpd_pkg::ST_END: begin
        if (!end_q) begin
          state_d = amrpd_pkg::ST_IDLE;
        end else if (slot_free) begin
          push = 1'b1;
          if ({1'b0, mode_q} >= req_q) begin
            mode_d = req_q[2:0];
          end
          res_new.item_kind    = amrpd_pkg::KIND_END;
          res_new.payload_done = 1'b1;
          res_new.encoder_mode = ({1'b0, mode_q} >= req_q) ? req_q[2:0] : mode_q;
          res_new.error_status = (phase_q == amrpd_pkg::PH_TOC ||
                                  phase_q == amrpd_pkg::PH_SPEECH) ?
                                 amrpd_pkg::ERR_TRUNCATED : latch_q;
          phase_d  = amrpd_pkg::PH_CMR;
          count_d  = '0;
          cursor_d = '0;
          left_d   = 8'd0;
          latch_d  = amrpd_pkg::ERR_OK;
          res_d    = 16'd0;
          fill_d   = 5'd0;
          state_d  = amrpd_pkg::ST_IDLE;
        end
      end

      default: state_d = amrpd_pkg::ST_IDLE;
    endcase

    // cfg write loads kept mode at once; the user writes only while idle, unchecked
    if (cfg_valid_i && cfg_index_i == {1'b0, amrpd_pkg::CFG_DEFAULT_MODE}) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= amrpd_pkg::ST_IDLE;
      phase_q  <= amrpd_pkg::PH_CMR;
      res_q    <= 16'd0;
      fill_q   <= 5'd0;
      count_q  <= '0;
      cursor_q <= '0;
      left_q   <= 8'd0;
      req_q    <= amrpd_pkg::RequestReset;
      mode_q   <= amrpd_pkg::ModeReset;
      latch_q  <= amrpd_pkg::ERR_OK;
      octet_q  <= 1'b0;
      cnt_q    <= 5'd0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      res_q    <= res_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      left_q   <= left_d;
      req_q    <= req_d;
      mode_q   <= mode_d;
      latch_q  <= latch_d;
      cnt_q    <= cnt_d;
      if (cfg_valid_i && cfg_index_i == {1'b0, amrpd_pkg::CFG_OCTET_ALIGNED}) begin
        octet_q <= cfg_data_i[0];
      end
    end
  end

  // payload of the accepted request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= payload_byte_i;
      end_q  <= payload_end_i;
    end
  end

endmodule

// ----- rtl/amrpd_toc_mem.sv -----
// TOC entry store: one write port, one read port, registered read data.
module amrpd_toc_mem #(
  parameter int unsigned Depth = amrpd_pkg::MaxFramesDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [6:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [6:0]       rdata_o
);

  logic [6:0] mem [Depth];
  logic [6:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/amrpd_out_reg.sv -----
// Output register holding one result request until the sink takes it.
module amrpd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  amrpd_pkg::result_t res_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output amrpd_pkg::result_t res_o
);

  logic               valid_q;
  amrpd_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
